/* hdl/uapq_pkg.sv */
// Shared types and constants for the unsorted-array priority queue.
package uapq_pkg;

	localparam int Capacity = 64;
	localparam int TagBits  = 16;
	localparam int AddrW    = $clog2(Capacity);
	localparam int CountW   = $clog2(Capacity + 1);

	typedef enum logic [1:0] {
		FN_INSERT  = 2'd0,
		FN_EXTRACT = 2'd1,
		FN_PEEK    = 2'd2,
		FN_MODIFY  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [15:0]        tag;
		logic signed [31:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [15:0]        out_tag;
		logic signed [31:0] out_priority;
		status_t            status;
		logic [6:0]         count;
	} rsp_t;

	typedef struct packed {
		logic [TagBits-1:0] tag;
		logic signed [31:0] pri;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_run;
		logic shift_start;
		logic shift_run;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic  empty;
		logic  pass_done;
		func_t func;
	} dp_sts_t;

endpackage

/* hdl/uapq_ctrl.sv */
// Controller state machine for the priority queue: sequences scan, shift and finish.
module uapq_ctrl import uapq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  func_t    req_func,
	input  dp_sts_t  sts,
	output logic     busy,
	output ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (req_func == FN_INSERT || (sts.empty && req_func != FN_MODIFY)) begin
						state_d = S_FIN;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.pass_done) begin
					if (sts.func == FN_EXTRACT) begin
						cmd.shift_start = 1'b1;
						state_d         = S_SHIFT;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_SHIFT: begin
				cmd.shift_run = 1'b1;
				if (sts.pass_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/uapq_datapath.sv */
// Datapath for the priority queue: entry memory, scan pipeline, count and result registers.
module uapq_datapath import uapq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output dp_sts_t  sts,
	output logic     done,
	output rsp_t     rsp
);

	entry_t mem [Capacity];

	func_t              func_q;
	logic [TagBits-1:0] tag_q;
	logic signed [31:0] pri_q;

	logic [CountW-1:0]  count_q;
	logic [CountW-1:0]  ptr_q;
	logic               rv_s1;
	logic [AddrW-1:0]   idx_s1;
	entry_t             rd_s1;

	logic [AddrW-1:0]   best_idx_q;
	entry_t             best_q;
	logic               found_q;
	logic [AddrW-1:0]   found_idx_q;

	logic               done_q;
	rsp_t               rsp_q, rsp_d;

	logic               issue;
	logic               full;
	logic               wr_en;
	logic [AddrW-1:0]   wr_addr;
	entry_t             wr_data;
	logic [CountW-1:0]  count_d;

	assign issue = (cmd.scan_run || cmd.shift_run) && (ptr_q != count_q);
	assign full  = (count_q == CountW'(Capacity));

	assign sts.empty     = (count_q == '0);
	assign sts.pass_done = (ptr_q == count_q) && !rv_s1;
	assign sts.func      = func_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			tag_q  <= req.tag[TagBits-1:0];
			pri_q  <= req.priority_req;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1 - AddrW'(1);
		wr_data = rd_s1;
		if (cmd.shift_run && rv_s1) begin
			wr_en = 1'b1;
		end else if (cmd.finish) begin
			if (func_q == FN_INSERT && !full) begin
				wr_en   = 1'b1;
				wr_addr = count_q[AddrW-1:0];
				wr_data = '{tag: tag_q, pri: pri_q};
			end else if (func_q == FN_MODIFY && found_q) begin
				wr_en   = 1'b1;
				wr_addr = found_idx_q;
				wr_data = '{tag: tag_q, pri: pri_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_s1 <= mem[ptr_q[AddrW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= issue;
			priority if (cmd.scan_start) begin
				ptr_q <= '0;
			end else if (cmd.shift_start) begin
				ptr_q <= CountW'(best_idx_q) + CountW'(1);
			end else if (issue) begin
				ptr_q <= ptr_q + CountW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= ptr_q[AddrW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run && rv_s1) begin
			if (idx_s1 == '0 || rd_s1.pri > best_q.pri) begin
				best_q     <= rd_s1;
				best_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			found_q <= 1'b0;
		end else if (cmd.scan_run && rv_s1 && !found_q && rd_s1.tag == tag_q) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run && rv_s1 && !found_q && rd_s1.tag == tag_q) begin
			found_idx_q <= idx_s1;
		end
	end

	always_comb begin
		count_d             = count_q;
		rsp_d.out_tag       = '0;
		rsp_d.out_priority  = '0;
		rsp_d.status        = ST_OK;
		unique case (func_q)
			FN_INSERT: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + CountW'(1);
				end
			end
			FN_EXTRACT, FN_PEEK: begin
				if (count_q == '0) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.out_tag      = 16'(best_q.tag);
					rsp_d.out_priority = best_q.pri;
					if (func_q == FN_EXTRACT) begin
						count_d = count_q - CountW'(1);
					end
				end
			end
			FN_MODIFY: begin
				if (!found_q) begin
					rsp_d.status = ST_NOTFOUND;
				end
			end
			default: begin
				rsp_d.status = ST_OK;
			end
		endcase
		rsp_d.count = 7'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* hdl/unsorted_array_priority_queue.sv */
// Top level of the unsorted-array max-priority queue.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  request  | start (in), busy (out) | req: func, tag, priority_req
//  result   | done strobe (out)      | rsp: out_tag, out_priority, status, count
//
// Insert, and extract or peek on an empty table, go straight to the finish state;
// peek and modify scan every entry, modify also on an empty table; extract scans,
// then shifts each entry above the max down by one, none when the max is the last
// entry. The passes are paced by the single read port of the entry memory, one
// entry per cycle in each pass.
// Reset clears the count and control; no clearing pass runs. Results are not stalled.
module unsorted_array_priority_queue import uapq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	uapq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_func (req.func),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	uapq_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (done && !busy))
		else $error("finish not followed by result strobe");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.count <= 7'(Capacity)))
		else $error("entry count beyond capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_EMPTY) |-> (rsp.count == '0))
		else $error("empty status with nonzero count");

endmodule

/* dv/uapq_checker.sv */
// Checker for the unsorted-array priority queue: predicts each result and compares it.
module uapq_checker import uapq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   errors,
	output int   outstanding
);

	logic [TagBits-1:0] held_tags [Capacity];
	logic signed [31:0] held_pris [Capacity];
	int                 fill;
	rsp_t               awaited [$];

	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		int   best;
		logic found;
		res = '0;
		res.status = ST_OK;
		case (r.func)
			FN_INSERT: begin
				if (fill >= Capacity) begin
					res.status = ST_FULL;
				end else begin
					held_tags[fill] = r.tag[TagBits-1:0];
					held_pris[fill] = r.priority_req;
					fill++;
				end
			end
			FN_EXTRACT, FN_PEEK: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					best = 0;
					for (int i = 1; i < fill; i++)
						if (held_pris[i] > held_pris[best])
							best = i;
					res.out_tag      = held_tags[best];
					res.out_priority = held_pris[best];
					if (r.func == FN_EXTRACT) begin
						for (int i = best; i < fill - 1; i++) begin
							held_tags[i] = held_tags[i + 1];
							held_pris[i] = held_pris[i + 1];
						end
						fill--;
					end
				end
			end
			default: begin
				found = 1'b0;
				for (int i = 0; i < fill; i++) begin
					if (!found && held_tags[i] == r.tag[TagBits-1:0]) begin
						held_pris[i] = r.priority_req;
						found = 1'b1;
					end
				end
				res.status = found ? ST_OK : ST_NOTFOUND;
			end
		endcase
		res.count = 7'(fill);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			awaited.delete();
			fill = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (awaited.size() == 0) begin
					$display("%0t: result with no item pending: tag %h pri %0d status %0d count %0d",
						$time, rsp.out_tag, rsp.out_priority, rsp.status, rsp.count);
					errors <= errors + 1;
				end else begin
					want = awaited.pop_front();
					if (rsp.out_tag !== want.out_tag || rsp.out_priority !== want.out_priority ||
						rsp.status !== want.status || rsp.count !== want.count) begin
						$display("%0t: expected tag %h pri %0d status %0d count %0d, got tag %h pri %0d status %0d count %0d",
							$time, want.out_tag, want.out_priority, want.status, want.count,
							rsp.out_tag, rsp.out_priority, rsp.status, rsp.count);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				awaited.push_back(apply_request(req));
			outstanding <= awaited.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// Testbench top for the unsorted-array priority queue: stimulus and verdict.
module tb_top;
	import uapq_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	int   errors;
	int   outstanding;

	int   burst_left = 0;
	int   issued = 0;
	int   depth = 0;

	unsorted_array_priority_queue DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	uapq_checker watch (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .errors(errors), .outstanding(outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("unsorted_array_priority_queue: mismatch");
		$finish;
	end

	task automatic issue(input func_t f, input logic [15:0] t, input logic signed [31:0] p);
		int idle;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
			if (idle > 0) begin
				start <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		req <= '{func: f, tag: t, priority_req: p};
		@(posedge clk);
		while (busy) @(posedge clk);
		issued++;
		case (f)
			FN_INSERT:  if (depth < Capacity) depth++;
			FN_EXTRACT: if (depth > 0) depth--;
			default: ;
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_tag();
		return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 15)) : 16'($urandom);
	endfunction

	function automatic logic signed [31:0] pick_pri();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return 32'($urandom_range(0, 16)) - 32'sd8;
		if (r < 11) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		return 32'($urandom);
	endfunction

	task automatic random_item(input int ins_w, input int ext_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_w)
			issue(FN_INSERT, pick_tag(), pick_pri());
		else if (r < ins_w + ext_w)
			issue(FN_EXTRACT, pick_tag(), pick_pri());
		else if (r < ins_w + ext_w + (100 - ins_w - ext_w) / 2)
			issue(FN_PEEK, pick_tag(), pick_pri());
		else
			issue(FN_MODIFY, pick_tag(), pick_pri());
	endtask

	initial begin
		int phase;
		int len;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(FN_PEEK, 16'h0000, 32'sd0);
		issue(FN_EXTRACT, 16'hffff, 32'sh7fff_ffff);
		issue(FN_MODIFY, 16'h0000, 32'sd3);
		issue(FN_INSERT, 16'h0000, 32'sh8000_0000);
		issue(FN_INSERT, 16'hffff, 32'sh7fff_ffff);
		issue(FN_INSERT, 16'h1234, 32'sh7fff_ffff);
		issue(FN_INSERT, 16'h5555, 32'sd0);
		issue(FN_INSERT, 16'haaaa, -32'sd1);
		issue(FN_INSERT, 16'h0000, 32'sd5);
		issue(FN_PEEK, 16'h0000, 32'sd0);
		issue(FN_MODIFY, 16'h0000, 32'sd7);
		issue(FN_MODIFY, 16'hbeef, 32'sd9);
		issue(FN_MODIFY, 16'hffff, 32'sh8000_0000);
		issue(FN_EXTRACT, 16'h0000, 32'sd0);
		issue(FN_PEEK, 16'h0000, 32'sd0);
		repeat (6) issue(FN_EXTRACT, 16'h0000, 32'sd0);
		issue(FN_PEEK, 16'hffff, -32'sd1);
		drain();

		phase = 0;
		while (issued < 620) begin
			if (phase == 0 || $urandom_range(0, 9) == 0) begin
				// grow to full, then push past it
				while (depth < Capacity) random_item(85, 5);
				repeat ($urandom_range(2, 4)) issue(FN_INSERT, pick_tag(), pick_pri());
				repeat ($urandom_range(1, 4)) random_item(0, 0);
			end else if ($urandom_range(0, 3) == 0) begin
				while (depth > 0) random_item(10, 80);
				issue(FN_EXTRACT, pick_tag(), pick_pri());
				if ($urandom_range(0, 1) == 0)
					issue(FN_PEEK, pick_tag(), pick_pri());
				else
					issue(FN_MODIFY, pick_tag(), pick_pri());
			end else begin
				len = $urandom_range(10, 40);
				repeat (len) random_item(depth < 8 ? 50 : 35, 30);
			end
			if ($urandom_range(0, 19) == 0)
				drain();
			phase++;
		end

		drain();
		repeat (2 * Capacity + 8) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("unsorted_array_priority_queue: match");
		else
			$display("unsorted_array_priority_queue: mismatch");
		$finish;
	end

endmodule
